/* rtl/lvfa_pkg.sv */
// ----------------------------------------------------------------------------
// lvfa_pkg: shared types and constants
// Types and constants used by the line fixture admittance block.
// ----------------------------------------------------------------------------
package lvfa_pkg;

    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_START_X   = 3'd0,
        REG_START_Y   = 3'd1,
        REG_START_Z   = 3'd2,
        REG_DIR_X     = 3'd3,
        REG_DIR_Y     = 3'd4,
        REG_DIR_Z     = 3'd5,
        REG_STIFFNESS = 3'd6,
        REG_DAMPING   = 3'd7
    } cfg_idx_t;

    localparam logic OP_SPRING = 1'b0;
    localparam logic OP_FORCE  = 1'b1;

    localparam logic [16:0] PHASE_ONE = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FORCE,
        ST_TORQUE,
        ST_LENSQ,
        ST_DIVISOR,
        ST_DIVIDE,
        ST_RATE,
        ST_PHASE,
        ST_POINT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic force_step;
        logic torque_step;
        logic lensq_step;
        logic divisor_step;
        logic div_start;
        logic rate_step;
        logic phase_step;
        logic point_step;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

/* rtl/lvfa_ctrl.sv */
// ----------------------------------------------------------------------------
// lvfa_ctrl: step sequencer
// Walks the datapath through force, torque, divide, integrate and output.
// ----------------------------------------------------------------------------
module lvfa_ctrl
    import lvfa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_fire,
    input  stat_t stat,
    output logic  busy,
    output logic  out_valid,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        busy       = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = 2'd0;
                    state_next = ST_FORCE;
                end
            end
            ST_FORCE:
            begin
                cmd.force_step = 1'b1;
                state_next = ST_TORQUE;
            end
            ST_TORQUE:
            begin
                cmd.torque_step = 1'b1;
                cmd.lensq_step  = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_LENSQ;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_FORCE;
                end
            end
            ST_LENSQ:
            begin
                state_next = ST_DIVISOR;
            end
            ST_DIVISOR:
            begin
                cmd.divisor_step = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                if (stat.div_done)
                begin
                    cmd.rate_step = 1'b1;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                cmd.phase_step = 1'b1;
                axis_next  = 2'd0;
                state_next = ST_POINT;
            end
            ST_POINT:
            begin
                cmd.point_step = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lvfa_div.sv */
// ----------------------------------------------------------------------------
// lvfa_div: serial divider
// Restoring divider, one quotient bit per cycle, 48-bit operands.
// ----------------------------------------------------------------------------
module lvfa_div
    import lvfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [47:0] divisor,
    output logic [47:0] quotient,
    output logic        done
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic [47:0] q_reg, q_next;
    logic [48:0] r_reg, r_next;
    logic [47:0] d_reg, d_next;
    logic [48:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        run_next = run_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        shifted  = {r_reg[47:0], q_reg[47]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 6'd0;
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                run_next = 1'b0;
            end
        end
    end

    assign quotient = q_reg;
    assign done     = !run_reg && !start;

endmodule

/* rtl/lvfa_dp.sv */
// ----------------------------------------------------------------------------
// lvfa_dp: datapath
// Configuration registers, mechanism state and the per-axis arithmetic.
// ----------------------------------------------------------------------------
module lvfa_dp
    import lvfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [31:0]         cfg_data,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [208:0]        in_data,
    output logic [241:0]        out_data
);

    logic signed [31:0] start_reg [3];
    logic signed [31:0] dir_reg [3];
    logic [31:0]        stiff_reg;
    logic [31:0]        damp_reg;
    logic [16:0]        phase_reg;
    logic signed [31:0] point_reg [3];

    logic               op_reg;
    logic signed [31:0] a_reg [3];
    logic signed [31:0] v_reg [3];
    logic [15:0]        dt_reg;

    logic signed [31:0] f_reg;
    logic signed [65:0] torque_reg;
    logic [65:0]        lensq_reg;
    logic [47:0]        divisor_reg;
    logic signed [31:0] rate_reg;
    logic               degen_reg;
    logic signed [31:0] spd_reg [3];

    logic signed [31:0] ax, vx, dx, px, diff, kt, bt;
    logic signed [63:0] kprod, bprod, tprod, sprod, ptprod;
    logic [31:0]        mag;
    logic [31:0]        lensq_sat;
    logic [63:0]        divprod;
    logic signed [31:0] torque_sat;
    logic [31:0]        tmag;
    logic [47:0]        quot;
    logic               ddone;
    logic [32:0]        qclamp;
    logic signed [33:0] rate_s;
    logic signed [49:0] rdt;
    logic signed [34:0] ph_sum;
    logic [16:0]        ph_new;

    lvfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({tmag, 16'd0}),
        .divisor  (divisor_reg),
        .quotient (quot),
        .done     (ddone)
    );

    assign stat.div_done = ddone;

    always_comb
    begin
        ax    = a_reg[cmd.axis];
        vx    = v_reg[cmd.axis];
        dx    = dir_reg[cmd.axis];
        px    = point_reg[cmd.axis];
        diff  = sat32(66'(px) - 66'(ax));
        kprod = 64'(diff) * $signed({32'd0, stiff_reg});
        bprod = 64'(vx) * $signed({32'd0, damp_reg});
        kt    = sat32(66'(kprod >>> 16));
        bt    = sat32(66'(bprod >>> 16));
        tprod = 64'(dx) * 64'(f_reg);
        mag   = dx[31] ? 32'(-dx) : 32'(dx);
        lensq_sat  = (lensq_reg[65:16] > 50'hFFFFFFFF) ? 32'hFFFFFFFF
                                                       : lensq_reg[47:16];
        divprod    = 64'(damp_reg) * 64'(lensq_sat);
        torque_sat = sat32(torque_reg);
        tmag       = torque_sat[31] ? 32'(-33'(torque_sat)) : 32'(torque_sat);
        qclamp     = (quot > 48'h80000000) ? 33'h80000000 : quot[32:0];
        rate_s     = torque_sat[31] ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
        rdt        = 50'(rate_reg) * $signed({34'd0, dt_reg});
        ph_sum     = 35'($signed({1'b0, phase_reg})) + 35'(rdt >>> 16);
        if (ph_sum < 0)
            ph_new = 17'd0;
        else if (ph_sum > 35'(PHASE_ONE))
            ph_new = PHASE_ONE;
        else
            ph_new = ph_sum[16:0];
        ptprod = $signed({47'd0, phase_reg}) * 64'(dx);
        sprod  = 64'(dx) * 64'(rate_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg[0] <= 32'sd32768;
            start_reg[1] <= -32'sd32768;
            start_reg[2] <= -32'sd13107;
            dir_reg[0]   <= '0;
            dir_reg[1]   <= '0;
            dir_reg[2]   <= '0;
            stiff_reg    <= 32'd4587520;
            damp_reg     <= 32'd1096631;
            phase_reg    <= '0;
            point_reg[0] <= '0;
            point_reg[1] <= '0;
            point_reg[2] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_idx))
                    REG_START_X:   start_reg[0] <= cfg_data;
                    REG_START_Y:   start_reg[1] <= cfg_data;
                    REG_START_Z:   start_reg[2] <= cfg_data;
                    REG_DIR_X:     dir_reg[0]   <= cfg_data;
                    REG_DIR_Y:     dir_reg[1]   <= cfg_data;
                    REG_DIR_Z:     dir_reg[2]   <= cfg_data;
                    REG_STIFFNESS: stiff_reg    <= cfg_data;
                    REG_DAMPING:   damp_reg     <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.phase_step)
            begin
                phase_reg <= ph_new;
            end
            if (cmd.point_step)
            begin
                point_reg[cmd.axis] <= sat32(66'(start_reg[cmd.axis])
                                             + 66'(ptprod >>> 16));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_data[0];
            a_reg[0]   <= in_data[32:1];
            a_reg[1]   <= in_data[64:33];
            a_reg[2]   <= in_data[96:65];
            v_reg[0]   <= in_data[128:97];
            v_reg[1]   <= in_data[160:129];
            v_reg[2]   <= in_data[192:161];
            dt_reg     <= in_data[208:193];
            torque_reg <= '0;
            lensq_reg  <= '0;
        end
        if (cmd.force_step)
        begin
            f_reg <= (op_reg == OP_FORCE) ? ax : sat32(66'(kt) - 66'(bt));
        end
        if (cmd.torque_step)
        begin
            torque_reg <= torque_reg + 66'(tprod >>> 16);
        end
        if (cmd.lensq_step)
        begin
            lensq_reg <= lensq_reg + 66'(64'(mag) * 64'(mag));
        end
        if (cmd.divisor_step)
        begin
            divisor_reg <= divprod[63:16];
        end
        if (cmd.rate_step)
        begin
            degen_reg <= (divisor_reg == '0);
            rate_reg  <= (divisor_reg == '0) ? 32'sd0 : sat32(66'(rate_s));
        end
        if (cmd.point_step)
        begin
            spd_reg[cmd.axis] <= sat32(66'(sprod >>> 16));
        end
    end

    assign out_data = {degen_reg, rate_reg, phase_reg,
                       spd_reg[2], spd_reg[1], spd_reg[0],
                       point_reg[2], point_reg[1], point_reg[0]};

endmodule

/* rtl/linear_virtual_fixture_admittance.sv */
// ----------------------------------------------------------------------------
// linear_virtual_fixture_admittance: line virtual fixture, admittance form
// Moves a mechanism point along a configured line from force input.
// ----------------------------------------------------------------------------
// An input transaction is taken only while the block is idle. After the
// accepting edge come the per-axis force and torque steps (the squared length
// accumulates beside the torque), a state for the squared length, one to form
// the divisor and one to start the divider. The phase rate is taken once the
// divider is done; then the phase is updated, the point and speed are updated
// axis by axis, and the result is offered and held until it is taken. Only
// then does the block return to idle and accept the next input.
module linear_virtual_fixture_admittance
    import lvfa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // a_x, a_y, a_z, vel_x, vel_y, vel_z, time_step
    input  logic [207:0]  s_tdata,
    // op
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // point_out_x/y/z, speed_x/y/z, phase_out, phase_rate, zero fill
    output logic [247:0]  m_tdata,
    // degenerate
    output logic [0:0]    m_tuser
);

    cmd_t  cmd;
    stat_t stat;
    logic  busy;
    logic  [241:0] out_data;

    assign s_tready = !busy;

    lvfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_tvalid && s_tready),
        .out_fire  (m_tvalid && m_tready),
        .stat      (stat),
        .busy      (busy),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    lvfa_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_addr),
        .cfg_data (cfg_wdata),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  ({s_tdata, s_tuser}),
        .out_data (out_data)
    );

    assign m_tdata = {7'd0, out_data[240:0]};
    assign m_tuser = out_data[241:241];

endmodule

/* rtl/lvfa_checker.sv */
// ----------------------------------------------------------------------------
// lvfa_checker: port checker
// Checks handshake and result ranges at the top-level ports.
// ----------------------------------------------------------------------------
module lvfa_checker
    import lvfa_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [247:0] m_tdata,
    input logic [0:0]   m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");

    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[208:192] <= PHASE_ONE)
        else $error("phase out of range");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[240:209] == 32'd0)
        else $error("degenerate step with nonzero rate");

endmodule

bind linear_virtual_fixture_admittance lvfa_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
